>>> rtl/core/rwalk_pkg.sv
// rwalk_pkg: shared types, register codes and constants of the two-lane random walk
// holds the beat structs, the generator control/status structs and both state enums
// depends on nothing
`timescale 1ns / 1ps

package rwalk_pkg;

  // pcg32 lcg multiplier and the 31-bit fraction scale
  localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
  localparam logic [30:0] FRAC_ONE = 31'h7FFF_FFFF;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEQUENCE   = 3'd4;

  // register reset values
  localparam logic [30:0] JUMP_RESET = 31'd0;
  localparam logic [30:0] MOVE_RESET = 31'd1073741823;
  localparam logic [15:0] STEP_RESET = 16'd1;
  localparam logic [63:0] SEED_RESET = 64'd123456789;
  localparam logic [62:0] SEQ_RESET  = 63'd0;

  // generator reset: increment and the state just before the final seeding advance
  localparam logic [63:0] INC_RESET   = {SEQ_RESET, 1'b1};
  localparam logic [63:0] STATE_RESET = INC_RESET + SEED_RESET;

  // input and output beats
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic               lane_y;
    logic               last_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic               new_y;
    logic               last_out;
  } out_beat_t;

  // requests from the walk sequencer to the generator
  typedef struct packed {
    logic        start;
    logic        reseed;
    logic [63:0] seed;
    logic [62:0] seq;
  } rng_ctl_t;

  // generator status: draw is valid while done is high
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [30:0] draw;
  } rng_sts_t;

  typedef enum logic [2:0] {
    RNG_IDLE,
    RNG_MUL_LL,
    RNG_MUL_HL,
    RNG_MUL_LH,
    RNG_ADD
  } rng_state_e;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_RUN,
    WALK_DONE
  } walk_state_e;

endpackage

>>> rtl/core/rwalk_rng.sv
// rwalk_rng: pcg32 xsh-rr generator built on one shared 32x32 multiplier
// one lcg advance runs three partial products, then the increment add
// depends on rwalk_pkg
`timescale 1ns / 1ps

module rwalk_rng import rwalk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rng_ctl_t ctl_i,
  output rng_sts_t sts_o
);

  rng_state_e  state_q, state_d;
  logic [63:0] lcg_q, lcg_d;
  logic [63:0] inc_q, inc_d;
  logic [63:0] acc_q, acc_d;
  logic [30:0] draw_q, draw_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] xs_shift;
  logic [31:0] xs_mixed;
  logic [63:0] xs_twice;
  logic [63:0] xs_rot;
  logic [63:0] new_inc;

  // xsh-rr output of the current (old) state
  assign xs_shift = (lcg_q ^ (lcg_q >> 18)) >> 27;
  assign xs_mixed = xs_shift[31:0];
  assign xs_twice = {xs_mixed, xs_mixed} >> lcg_q[63:59];
  assign xs_rot   = xs_twice;

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      RNG_MUL_HL: begin
        mul_a = lcg_q[63:32];
        mul_b = LCG_MULT[31:0];
      end
      RNG_MUL_LH: begin
        mul_a = lcg_q[31:0];
        mul_b = LCG_MULT[63:32];
      end
      default: begin
        mul_a = lcg_q[31:0];
        mul_b = LCG_MULT[31:0];
      end
    endcase
  end

  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign new_inc = {ctl_i.seq, 1'b1};

  // advance sequencer
  always_comb begin
    state_d = state_q;
    lcg_d   = lcg_q;
    inc_d   = inc_q;
    acc_d   = acc_q;
    draw_d  = draw_q;
    unique case (state_q)
      RNG_IDLE: begin
        if (ctl_i.start) state_d = RNG_MUL_LL;
      end
      RNG_MUL_LL: begin
        acc_d   = prod;
        draw_d  = xs_rot[30:0];
        state_d = RNG_MUL_HL;
      end
      RNG_MUL_HL: begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
        state_d      = RNG_MUL_LH;
      end
      RNG_MUL_LH: begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
        state_d      = RNG_ADD;
      end
      RNG_ADD: begin
        lcg_d   = acc_q + inc_q;
        state_d = ctl_i.start ? RNG_MUL_LL : RNG_IDLE;
      end
      default: state_d = RNG_IDLE;
    endcase
    // reseed: state = inc + seed, then one advance
    if (ctl_i.reseed) begin
      inc_d   = new_inc;
      lcg_d   = new_inc + ctl_i.seed;
      state_d = RNG_MUL_LL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RNG_MUL_LL;
      lcg_q   <= STATE_RESET;
      inc_q   <= INC_RESET;
    end else begin
      state_q <= state_d;
      lcg_q   <= lcg_d;
      inc_q   <= inc_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    draw_q <= draw_d;
  end

  assign sts_o.busy = (state_q != RNG_IDLE);
  assign sts_o.done = (state_q == RNG_ADD);
  assign sts_o.draw = draw_q;

endmodule

>>> rtl/core/two_lane_random_walk_step_top.sv
// Draws: 1 or 2 draws per step, between step_count and 2*step_count draws per input beat.
// Throughput: one item at a time; the next input beat is taken only once the walk and the
//   generator are idle again; a stalled result holds the walk until taken.
// Reset: the control and configuration registers take their reset values and the generator
//   runs its final seeding advance before the first item is taken; a seed write does the same.
// depends on rwalk_pkg and rwalk_rng
`timescale 1ns / 1ps

module two_lane_random_walk_step_top import rwalk_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_beat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_wdata_i
);

  localparam logic [POSITION_WIDTH-1:0] XOne = POSITION_WIDTH'(1);

  // configuration registers
  logic [30:0] jump_q;
  logic [30:0] move_q;
  logic [15:0] steps_q;
  logic [62:0] seq_q;

  walk_state_e               state_q, state_d;
  logic [POSITION_WIDTH-1:0] x_q, x_d;
  logic                      y_q, y_d;
  logic                      last_q, last_d;
  logic [15:0]               cnt_q, cnt_d;
  logic                      second_q, second_d;
  logic                      out_valid_q, out_valid_d;
  out_beat_t                 out_q, out_d;

  rng_ctl_t    rng_ctl;
  rng_sts_t    rng_sts;
  logic        rng_start;
  logic        in_take;
  logic [63:0] pos_ext;
  logic [63:0] x_zext;
  logic [30:0] move_t;

  rwalk_rng u_rng (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (rng_ctl),
    .sts_o (rng_sts)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_q  <= JUMP_RESET;
      move_q  <= MOVE_RESET;
      steps_q <= STEP_RESET;
      seq_q   <= SEQ_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_JUMP_THRESHOLD: jump_q  <= cfg_wdata_i[30:0];
        CFG_MOVE_THRESHOLD: move_q  <= cfg_wdata_i[30:0];
        CFG_STEP_COUNT:     steps_q <= cfg_wdata_i[15:0];
        CFG_RNG_SEQUENCE:   seq_q   <= cfg_wdata_i[62:0];
        default: ;
      endcase
    end
  end

  assign rng_ctl.start  = rng_start;
  assign rng_ctl.reseed = cfg_we_i && (cfg_idx_i == CFG_RNG_SEED);
  assign rng_ctl.seed   = cfg_wdata_i;
  assign rng_ctl.seq    = seq_q;

  // input side only while both sequencers rest
  assign in_stall_o = !((state_q == WALK_IDLE) && !rng_sts.busy);
  assign in_take    = in_valid_i && !in_stall_o;

  assign pos_ext = 64'(in_beat_i.pos_x);
  assign x_zext  = 64'(x_q);
  assign move_t  = y_q ? move_q : (FRAC_ONE - move_q);

  // walk sequencer
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    second_d    = second_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rng_start   = 1'b0;
    unique case (state_q)
      WALK_IDLE: begin
        if (in_take) begin
          x_d      = pos_ext[POSITION_WIDTH-1:0];
          y_d      = in_beat_i.lane_y;
          last_d   = in_beat_i.last_in;
          cnt_d    = steps_q;
          second_d = 1'b0;
          if (steps_q == 16'd0) begin
            state_d = WALK_DONE;
          end else begin
            rng_start = 1'b1;
            state_d   = WALK_RUN;
          end
        end
      end
      WALK_RUN: begin
        if (rng_sts.done) begin
          if (!second_q && (rng_sts.draw < jump_q)) begin
            // lane jump ends the step
            y_d = !y_q;
          end else if (!second_q) begin
            // no jump: draw again for the move direction
            second_d  = 1'b1;
            rng_start = 1'b1;
          end else if (rng_sts.draw > move_t) begin
            x_d = x_q + XOne;
          end else begin
            x_d = x_q - XOne;
          end
          // step end
          if (second_q || (rng_sts.draw < jump_q)) begin
            second_d = 1'b0;
            if (cnt_q == 16'd1) begin
              state_d = WALK_DONE;
            end else begin
              cnt_d     = cnt_q - 16'd1;
              rng_start = 1'b1;
            end
          end
        end
      end
      WALK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.new_x    = x_zext[31:0];
          out_d.new_y    = y_q;
          out_d.last_out = last_q;
          out_valid_d    = 1'b1;
          state_d        = WALK_IDLE;
        end
      end
      default: state_d = WALK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WALK_IDLE;
      second_q    <= 1'b0;
      cnt_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
